@@ hdl/quad_incremental_pid_with_slaving_assert.svh @@
// Assertion macros used by the port-level checker of the quad PID block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef QUAD_INCREMENTAL_PID_WITH_SLAVING_ASSERT_SVH
`define QUAD_INCREMENTAL_PID_WITH_SLAVING_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QIPID_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QIPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/qipid_pkg.sv @@
// Package of the quad incremental PID block: widths, register indexes and helpers.
// Used by the channel interfaces, the top level and the checker; depends on nothing.
`default_nettype none

package qipid_pkg;

  localparam int MOTORS     = 4;
  localparam int MOT_W      = 2;
  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 16;
  localparam int DRIVE_W    = 16;
  localparam int ERR_W      = 17;
  localparam int OPND_W     = 19;
  localparam int PROD_W     = GAIN_W + 1 + OPND_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int LIMIT_W    = 15;
  localparam int MASK_W     = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam int DEF_GAIN_FRAC_BITS = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd2000;

  localparam logic [CFG_IDX_W-1:0] REG_KP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE = 3'd4;

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic signed [DRIVE_W-1:0] drive_t;

  // Same-side partner of a motor: half the motor count further on, wrapping.
  function automatic logic [MOT_W-1:0] partner_of(input logic [MOT_W-1:0] m);
    return m + MOT_W'(MOTORS / 2);
  endfunction

endpackage

`default_nettype wire

@@ hdl/qipid_if.sv @@
// Request channels of the quad incremental PID block: control tick in, drive values out.
// Depends on qipid_pkg for the field types.
`default_nettype none

interface qipid_in_if;
  import qipid_pkg::*;
  logic                valid;
  logic                ready;
  speed_t              target_m0;
  speed_t              target_m1;
  speed_t              target_m2;
  speed_t              target_m3;
  speed_t              speed_m0;
  speed_t              speed_m1;
  speed_t              speed_m2;
  speed_t              speed_m3;
  logic [MASK_W-1:0]   clear_mask;

  modport source(output valid, target_m0, target_m1, target_m2, target_m3,
                 speed_m0, speed_m1, speed_m2, speed_m3, clear_mask, input ready);
  modport sink(input valid, target_m0, target_m1, target_m2, target_m3,
               speed_m0, speed_m1, speed_m2, speed_m3, clear_mask, output ready);
endinterface

interface qipid_out_if;
  import qipid_pkg::*;
  logic   valid;
  logic   ready;
  drive_t drive_m0;
  drive_t drive_m1;
  drive_t drive_m2;
  drive_t drive_m3;

  modport source(output valid, drive_m0, drive_m1, drive_m2, drive_m3, input ready);
  modport sink(input valid, drive_m0, drive_m1, drive_m2, drive_m3, output ready);
endinterface

`default_nettype wire

@@ hdl/qipid_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; holds the per-motor controller state of the PID block.
`default_nettype none

module qipid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/quad_incremental_pid_with_slaving.sv @@
// Four-motor incremental velocity PID with partner slaving.
// The input channel takes one control tick: target and measured speed per motor and
// a mask of motors whose accumulator and error history are zeroed first. The output
// channel returns one request with the four drive values of that tick.
// Configuration writes (gains, limit, slave mask) arrive on the cfg_ port; the user must
// send them only while idle, and the block itself does not enforce it. Each tick runs
// from acceptance through one memory read, then per motor a load step, the three gain
// products through the one shared multiplier and the write-back of the state entry,
// then one step to resolve slaved motors. Only then does the block return to idle and
// take a new tick, so ticks are worked on one at a time. The next tick may be accepted
// while the previous result still waits; its result is held until the output register
// is free, so a stalled receiver only holds off the final step.
// Reset returns gains to zero, the limit to 2000, clears the slave mask and the drive
// values, and marks every state entry stale so it reads as zero until written.
// Depends on qipid_pkg, qipid_if and qipid_ram.
`default_nettype none

module quad_incremental_pid_with_slaving #(
  parameter int GAIN_FRAC_BITS = qipid_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  qipid_in_if.sink                         in_chan,
  qipid_out_if.source                      out_chan,
  input  logic                             cfg_we,
  input  logic [qipid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qipid_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qipid_pkg::*;

  localparam int ACC_W = ERR_W + GAIN_FRAC_BITS;
  localparam int ENT_W = 2 * ERR_W + ACC_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_LD   = 4'd2;
  localparam logic [3:0] ST_M0   = 4'd3;
  localparam logic [3:0] ST_M1   = 4'd4;
  localparam logic [3:0] ST_M2   = 4'd5;
  localparam logic [3:0] ST_AD   = 4'd6;
  localparam logic [3:0] ST_WB   = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0]              state_r, state_nxt;
  logic [MOT_W-1:0]        mot_r;
  logic [CFG_DATA_W-1:0]   kp_r, ki_r, kd_r;
  logic [LIMIT_W-1:0]      limit_r;
  logic [MASK_W-1:0]       slave_r;
  logic [MASK_W-1:0]       zap_r;
  logic                    out_valid_r;

  speed_t                  tgt_r [MOTORS];
  speed_t                  spd_r [MOTORS];
  logic [MASK_W-1:0]       clr_r;
  logic signed [ERR_W-1:0] e_r, e1_r, e2_r;
  logic signed [OPND_W-1:0] d1_r, d2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0] sum_r;
  drive_t                  drive_r [MOTORS];
  drive_t                  out_drive_r [MOTORS];

  logic                    in_acc;
  logic                    out_free;
  logic                    zap_c;
  logic [ENT_W-1:0]        ram_rdata, ram_wdata;
  logic [MOT_W-1:0]        ram_raddr;
  logic                    ram_we;
  logic signed [ERR_W-1:0] ep_c, ep2_c, e_c;
  logic signed [ACC_W-1:0] accq_c, accn_c;
  logic signed [OPND_W-1:0] d1_c, d2_c, opnd_c;
  logic [GAIN_W-1:0]       gain_c;
  logic signed [GAIN_W:0]  gain_s_c;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [SUM_W-1:0] lim_c, clamp_c;
  logic [ACC_W-1:0]        mag_c;
  drive_t                  drive_c;
  drive_t                  nd_c [MOTORS];
  logic [MASK_W-1:0]       slave_new_c;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);

  assign out_chan.valid    = out_valid_r;
  assign out_chan.drive_m0 = out_drive_r[0];
  assign out_chan.drive_m1 = out_drive_r[1];
  assign out_chan.drive_m2 = out_drive_r[2];
  assign out_chan.drive_m3 = out_drive_r[3];

  // Per-motor state memory: {error_prev, error_prev2, drive_accum}.
  qipid_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MOTORS)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(mot_r),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_raddr = (state_r == ST_WB) ? mot_r + MOT_W'(1) : mot_r;
  assign ram_we    = (state_r == ST_WB);

  // A stale or cleared entry reads as zero history.
  assign zap_c  = zap_r[mot_r] | clr_r[mot_r];
  assign ep_c   = zap_c ? '0 : ram_rdata[ENT_W-1 -: ERR_W];
  assign ep2_c  = zap_c ? '0 : ram_rdata[ACC_W +: ERR_W];
  assign accq_c = zap_c ? '0 : ram_rdata[ACC_W-1:0];
  assign e_c    = ERR_W'(tgt_r[mot_r]) - ERR_W'(spd_r[mot_r]);
  assign d1_c   = OPND_W'(e_c) - OPND_W'(ep_c);
  assign d2_c   = OPND_W'(e_c) - (OPND_W'(ep_c) <<< 1) + OPND_W'(ep2_c);

  always_comb begin
    case (state_r)
      ST_M0: begin
        gain_c = kp_r[mot_r*GAIN_W +: GAIN_W];
        opnd_c = d1_r;
      end
      ST_M1: begin
        gain_c = ki_r[mot_r*GAIN_W +: GAIN_W];
        opnd_c = OPND_W'(e_r);
      end
      default: begin
        gain_c = kd_r[mot_r*GAIN_W +: GAIN_W];
        opnd_c = d2_r;
      end
    endcase
  end

  assign gain_s_c = $signed({1'b0, gain_c});
  assign prod_c   = gain_s_c * opnd_c;

  assign lim_c = $signed(SUM_W'({limit_r, {GAIN_FRAC_BITS{1'b0}}}));

  always_comb begin
    if (sum_r > lim_c) begin
      clamp_c = lim_c;
    end else if (sum_r < -lim_c) begin
      clamp_c = -lim_c;
    end else begin
      clamp_c = sum_r;
    end
  end

  assign accn_c  = ACC_W'(clamp_c);
  assign mag_c   = accn_c[ACC_W-1] ? ACC_W'(-accn_c) : ACC_W'(accn_c);
  assign drive_c = accn_c[ACC_W-1] ? -DRIVE_W'(mag_c >> GAIN_FRAC_BITS)
                                   : DRIVE_W'(mag_c >> GAIN_FRAC_BITS);

  assign ram_wdata = slave_r[mot_r] ? {e1_r, e2_r, acc_r} : {e_r, e1_r, accn_c};

  // Slaved motors resolve in increasing index order against current values.
  always_comb begin
    for (int m = 0; m < MOTORS; m++) begin
      nd_c[m] = drive_r[m];
    end
    for (int m = 0; m < MOTORS; m++) begin
      if (slave_r[m]) begin
        nd_c[m] = -nd_c[partner_of(MOT_W'(m))];
      end
    end
  end

  assign slave_new_c = cfg_data[MASK_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_LD;
      ST_LD:   state_nxt = ST_M0;
      ST_M0:   state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_AD;
      ST_AD:   state_nxt = ST_WB;
      ST_WB:   state_nxt = (mot_r == MOT_W'(MOTORS - 1)) ? ST_FIN : ST_LD;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mot_r       <= '0;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      limit_r     <= LIMIT_RESET;
      slave_r     <= '0;
      zap_r       <= '1;
      out_valid_r <= 1'b0;
      for (int m = 0; m < MOTORS; m++) begin
        drive_r[m] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KP:    kp_r <= cfg_data;
          REG_KI:    ki_r <= cfg_data;
          REG_KD:    kd_r <= cfg_data;
          REG_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
          REG_SLAVE: begin
            slave_r <= slave_new_c;
            zap_r   <= zap_r | (slave_new_c ^ slave_r);
          end
          default: ;
        endcase
      end
      if (in_acc) begin
        mot_r <= '0;
      end
      if (state_r == ST_WB) begin
        mot_r        <= mot_r + MOT_W'(1);
        zap_r[mot_r] <= 1'b0;
        if (!slave_r[mot_r]) begin
          drive_r[mot_r] <= drive_c;
        end
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
        for (int m = 0; m < MOTORS; m++) begin
          drive_r[m] <= nd_c[m];
        end
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt_r[0] <= in_chan.target_m0;
      tgt_r[1] <= in_chan.target_m1;
      tgt_r[2] <= in_chan.target_m2;
      tgt_r[3] <= in_chan.target_m3;
      spd_r[0] <= in_chan.speed_m0;
      spd_r[1] <= in_chan.speed_m1;
      spd_r[2] <= in_chan.speed_m2;
      spd_r[3] <= in_chan.speed_m3;
      clr_r    <= in_chan.clear_mask;
    end
    if (state_r == ST_LD) begin
      e_r   <= e_c;
      e1_r  <= ep_c;
      e2_r  <= ep2_c;
      acc_r <= accq_c;
      d1_r  <= d1_c;
      d2_r  <= d2_c;
    end
    if (state_r == ST_M0 || state_r == ST_M1 || state_r == ST_M2) begin
      prod_r <= prod_c;
    end
    if (state_r == ST_M1) begin
      sum_r <= SUM_W'(acc_r) + SUM_W'(prod_r);
    end else if (state_r == ST_M2 || state_r == ST_AD) begin
      sum_r <= sum_r + SUM_W'(prod_r);
    end
    if (state_r == ST_FIN && out_free) begin
      for (int m = 0; m < MOTORS; m++) begin
        out_drive_r[m] <= nd_c[m];
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/qipid_checker.sv @@
// Port-level checker of the quad incremental PID block, bound to its top level.
// Depends on qipid_pkg and the assertion macros in the block's header.
`default_nettype none
`include "quad_incremental_pid_with_slaving_assert.svh"

module qipid_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [qipid_pkg::DRIVE_W-1:0] drive_m0,
  input wire logic [qipid_pkg::DRIVE_W-1:0] drive_m1,
  input wire logic [qipid_pkg::DRIVE_W-1:0] drive_m2,
  input wire logic [qipid_pkg::DRIVE_W-1:0] drive_m3
);
  import qipid_pkg::*;

  localparam logic [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W - 1){1'b0}}};

  // A tick is worked on alone, so a new request is refused right after one is taken.
  `QIPID_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken while busy")

  // No result can appear in the cycle after a request is taken.
  `QIPID_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result too early")

  // Saturated and negated drive values never reach the most negative code.
  `QIPID_ASSERT_IMPL(a_drive_range, out_valid, (drive_m0 != DRIVE_MIN) && (drive_m1 != DRIVE_MIN) && (drive_m2 != DRIVE_MIN) && (drive_m3 != DRIVE_MIN), "drive value out of range")

  // A stalled result holds.
  `QIPID_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive_m0) && $stable(drive_m1) && $stable(drive_m2) && $stable(drive_m3), "stalled result changed")

endmodule

bind quad_incremental_pid_with_slaving qipid_checker u_qipid_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_chan.valid),
  .in_ready (in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .drive_m0 (out_chan.drive_m0),
  .drive_m1 (out_chan.drive_m1),
  .drive_m2 (out_chan.drive_m2),
  .drive_m3 (out_chan.drive_m3)
);

`default_nettype wire

@@ test/qipid_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the quad incremental PID block. It mirrors the register writes,
// predicts the four drive values of every accepted control tick and compares them in order.
// Depends on qipid_pkg and the channel interfaces of qipid_if.
module qipid_result_checker #(
  parameter int FRAC_BITS = qipid_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  qipid_in_if                              in_mon,
  qipid_out_if                             out_mon,
  input  logic                             cfg_we,
  input  logic [qipid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qipid_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               fail_count,
  output int                               pending_count,
  output int                               checked_count
);
  import qipid_pkg::*;

  typedef logic [MOTORS-1:0][DRIVE_W-1:0] drive_set_t;

  logic [CFG_DATA_W-1:0] kp_gains;
  logic [CFG_DATA_W-1:0] ki_gains;
  logic [CFG_DATA_W-1:0] kd_gains;
  logic [LIMIT_W-1:0]    drive_limit;
  logic [MASK_W-1:0]     slaved;

  longint err_prior [MOTORS];
  longint err_older [MOTORS];
  longint accum [MOTORS];
  longint drive_now [MOTORS];

  drive_set_t expected_drives [$];

  function automatic longint gain_at(input logic [CFG_DATA_W-1:0] gains, input int m);
    return longint'(gains[GAIN_W*m +: GAIN_W]);
  endfunction

  task automatic zero_motor(input int m);
    err_prior[m] = 0;
    err_older[m] = 0;
    accum[m]     = 0;
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $time, what);
    fail_count++;
  endtask

  task automatic restore_defaults();
    int m;
    kp_gains    = '0;
    ki_gains    = '0;
    kd_gains    = '0;
    drive_limit = LIMIT_RESET;
    slaved      = '0;
    for (m = 0; m < MOTORS; m++) begin
      zero_motor(m);
      drive_now[m] = 0;
    end
    expected_drives.delete();
  endtask

  task automatic apply_reg_write();
    logic [MASK_W-1:0] changed;
    int m;
    case (cfg_index)
      REG_KP: begin
        kp_gains = cfg_data;
      end
      REG_KI: begin
        ki_gains = cfg_data;
      end
      REG_KD: begin
        kd_gains = cfg_data;
      end
      REG_LIMIT: begin
        drive_limit = cfg_data[LIMIT_W-1:0];
      end
      REG_SLAVE: begin
        changed = cfg_data[MASK_W-1:0] ^ slaved;
        slaved  = cfg_data[MASK_W-1:0];
        for (m = 0; m < MOTORS; m++) begin
          if (changed[m]) zero_motor(m);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic predict_drives();
    longint tgt [MOTORS];
    longint spd [MOTORS];
    longint lim;
    longint e;
    longint inc;
    longint acc;
    drive_set_t res;
    int m;
    tgt = '{in_mon.target_m0, in_mon.target_m1, in_mon.target_m2, in_mon.target_m3};
    spd = '{in_mon.speed_m0, in_mon.speed_m1, in_mon.speed_m2, in_mon.speed_m3};
    lim = longint'(drive_limit) <<< FRAC_BITS;
    for (m = 0; m < MOTORS; m++) begin
      if (in_mon.clear_mask[m]) zero_motor(m);
    end
    for (m = 0; m < MOTORS; m++) begin
      if (!slaved[m]) begin
        e   = tgt[m] - spd[m];
        inc = gain_at(kp_gains, m) * (e - err_prior[m])
            + gain_at(ki_gains, m) * e
            + gain_at(kd_gains, m) * (e - 2 * err_prior[m] + err_older[m]);
        err_older[m] = err_prior[m];
        err_prior[m] = e;
        acc = accum[m] + inc;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        accum[m] = acc;
        drive_now[m] = (acc < 0) ? -((-acc) >>> FRAC_BITS) : (acc >>> FRAC_BITS);
      end
    end
    // Slaved motors go in index order, so a slaved partner may already hold this tick's value.
    for (m = 0; m < MOTORS; m++) begin
      if (slaved[m]) drive_now[m] = -drive_now[(m + MOTORS / 2) % MOTORS];
    end
    for (m = 0; m < MOTORS; m++) begin
      res[m] = DRIVE_W'(drive_now[m]);
    end
    expected_drives.push_back(res);
  endtask

  task automatic check_drives();
    drive_set_t got;
    drive_set_t want;
    int m;
    got = {out_mon.drive_m3, out_mon.drive_m2, out_mon.drive_m1, out_mon.drive_m0};
    if (expected_drives.size() == 0) begin
      report_mismatch("drive values returned with no tick outstanding");
    end else begin
      want = expected_drives.pop_front();
      checked_count++;
      for (m = 0; m < MOTORS; m++) begin
        if (got[m] !== want[m]) begin
          report_mismatch($sformatf("result %0d drive_m%0d: got %0d, expected %0d",
                                    checked_count, m, $signed(got[m]), $signed(want[m])));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restore_defaults();
      fail_count    = 0;
      checked_count = 0;
    end else begin
      if (cfg_we) apply_reg_write();
      if (out_mon.valid && out_mon.ready) check_drives();
      if (in_mon.valid && in_mon.ready) predict_drives();
    end
    pending_count = expected_drives.size();
  end

endmodule

@@ test/tb_quad_incremental_pid_with_slaving.sv @@
`timescale 1ns / 1ps
// Top of the quad incremental PID testbench: clock, reset, register settings, control ticks
// and receiver stalls, plus the final verdict. Checking is done in qipid_result_checker.
// Depends on qipid_pkg, qipid_if, qipid_result_checker and the block itself.
module tb_quad_incremental_pid_with_slaving;
  import qipid_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 9;
  localparam int STALL_LIMIT     = 3000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int RANDOM_PHASES   = 8;
  localparam int TICKS_PER_PHASE = 50;

  // No register lives at this index; writes to it must leave everything unchanged.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending_count;
  int checked_count;
  int tick_count;
  int write_count;
  int idle_cycles;
  int stall_left;
  bit calm;

  qipid_in_if  in_if();
  qipid_out_if out_if();

  quad_incremental_pid_with_slaving u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  qipid_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 70);
  endfunction

  initial begin
    out_if.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Watchdog: no request moved for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_tick(input logic [MOTORS-1:0][SPEED_W-1:0] tgt,
                           input logic [MOTORS-1:0][SPEED_W-1:0] spd,
                           input logic [MASK_W-1:0] clr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.target_m0  <= tgt[0];
    in_if.target_m1  <= tgt[1];
    in_if.target_m2  <= tgt[2];
    in_if.target_m3  <= tgt[3];
    in_if.speed_m0   <= spd[0];
    in_if.speed_m1   <= spd[1];
    in_if.speed_m2   <= spd[2];
    in_if.speed_m3   <= spd[3];
    in_if.clear_mask <= clr;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    tick_count++;
  endtask

  task automatic send_uniform(input logic [SPEED_W-1:0] tgt, input logic [SPEED_W-1:0] spd,
                              input logic [MASK_W-1:0] clr);
    send_tick({MOTORS{tgt}}, {MOTORS{spd}}, clr);
  endtask

  task automatic send_random_tick();
    logic [MOTORS-1:0][SPEED_W-1:0] tgt;
    logic [MOTORS-1:0][SPEED_W-1:0] spd;
    logic [MASK_W-1:0] clr;
    int m;
    int mode;
    int base;
    for (m = 0; m < MOTORS; m++) begin
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        base   = int'($urandom_range(0, 8000)) - 4000;
        tgt[m] = SPEED_W'(base);
        spd[m] = SPEED_W'(base + int'($urandom_range(0, 400)) - 200);
      end else if (mode < 9) begin
        tgt[m] = SPEED_W'($urandom());
        spd[m] = SPEED_W'($urandom());
      end else begin
        tgt[m] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        spd[m] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      end
    end
    clr = ($urandom_range(0, 6) == 0) ? MASK_W'($urandom()) : '0;
    send_tick(tgt, spd, clr);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    write_count++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_gains();
    logic [CFG_DATA_W-1:0] g;
    int m;
    int pick;
    for (m = 0; m < MOTORS; m++) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) g[GAIN_W*m +: GAIN_W] = '0;
      else if (pick == 1) g[GAIN_W*m +: GAIN_W] = '1;
      else if (pick == 2) g[GAIN_W*m +: GAIN_W] = GAIN_W'($urandom());
      else g[GAIN_W*m +: GAIN_W] = GAIN_W'($urandom_range(0, 16'hFFFF) >> $urandom_range(4, 15));
    end
    return g;
  endfunction

  task automatic apply_random_setting();
    logic [LIMIT_W-1:0] lim;
    logic [CFG_DATA_W-1:0] junk;
    case ($urandom_range(0, 5))
      0: lim = '0;
      1: lim = '1;
      2: lim = LIMIT_RESET;
      3: lim = LIMIT_W'($urandom_range(1, 100));
      default: lim = LIMIT_W'($urandom());
    endcase
    junk = {$urandom(), $urandom()};
    wait_idle();
    write_reg(REG_KP, rand_gains());
    write_reg(REG_KI, rand_gains());
    write_reg(REG_KD, rand_gains());
    write_reg(REG_LIMIT, {junk[CFG_DATA_W-1:LIMIT_W], lim});
    write_reg(REG_SLAVE, {junk[CFG_DATA_W-1:MASK_W], MASK_W'($urandom())});
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase;
    int n;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_KP;
    cfg_data         <= '0;
    in_if.valid      <= 1'b0;
    in_if.target_m0  <= '0;
    in_if.target_m1  <= '0;
    in_if.target_m2  <= '0;
    in_if.target_m3  <= '0;
    in_if.speed_m0   <= '0;
    in_if.speed_m1   <= '0;
    in_if.speed_m2   <= '0;
    in_if.speed_m3   <= '0;
    in_if.clear_mask <= '0;
    calm        = 1'b0;
    tick_count  = 0;
    write_count = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Gains still at reset: every drive value must stay zero.
    send_uniform(16'sd100, 16'sd0, 4'b0000);

    wait_idle();
    write_reg(REG_KP, {16'h0040, 16'h0200, 16'h0080, 16'h0100});
    write_reg(REG_KI, {16'h0008, 16'h0020, 16'h0010, 16'h0040});
    write_reg(REG_KD, {16'h0004, 16'h0010, 16'h0020, 16'h0008});
    cfg_we <= 1'b0;
    send_uniform(16'h7FFF, 16'h8000, 4'b0000);
    send_uniform(16'h8000, 16'h7FFF, 4'b0000);
    send_uniform(16'sd0, 16'sd0, 4'b0000);
    send_uniform(16'sd500, 16'sd480, 4'b1111);
    send_tick({16'sd300, -16'sd250, 16'sd1200, -16'sd40},
              {16'sd310, -16'sd100, 16'sd1000, 16'sd20}, 4'b0101);
    send_tick({-16'sd700, 16'sd90, 16'sd5, 16'sd2500},
              {16'sd0, 16'sd95, -16'sd5, 16'sd2400}, 4'b1010);
    send_tick({16'sd64, 16'sd32, 16'sd16, 16'sd8}, {16'sd0, 16'sd0, 16'sd0, 16'sd0}, 4'b0000);

    wait_idle();
    write_reg(REG_KP, '1);
    write_reg(REG_KI, '1);
    write_reg(REG_KD, '1);
    write_reg(REG_LIMIT, 64'h7FFF);
    cfg_we <= 1'b0;
    send_uniform(16'h7FFF, 16'h8000, 4'b0000);
    send_uniform(16'h8000, 16'h7FFF, 4'b0000);

    wait_idle();
    write_reg(REG_LIMIT, 64'h0);
    cfg_we <= 1'b0;
    send_uniform(16'h7FFF, 16'h8000, 4'b0000);

    wait_idle();
    write_reg(REG_KP, {4{16'h0080}});
    write_reg(REG_KI, {4{16'h0020}});
    write_reg(REG_KD, {4{16'h0010}});
    write_reg(REG_LIMIT, 64'd1500);
    write_reg(REG_SLAVE, 64'b0100);
    cfg_we <= 1'b0;
    send_tick({16'sd900, 16'sd400, -16'sd300, 16'sd200}, {4{16'sd0}}, 4'b0000);
    send_tick({16'sd900, 16'sd400, -16'sd300, 16'sd200}, {4{16'sd50}}, 4'b0000);

    // Both partners of the left side slaved: motor 0 sees last tick's motor 2.
    wait_idle();
    write_reg(REG_SLAVE, 64'b0101);
    cfg_we <= 1'b0;
    send_tick({16'sd100, 16'sd800, 16'sd100, -16'sd600}, {4{16'sd0}}, 4'b0000);
    send_tick({16'sd100, 16'sd800, 16'sd100, -16'sd600}, {4{16'sd0}}, 4'b0000);
    send_tick({16'sd100, 16'sd800, 16'sd100, -16'sd600}, {4{16'sd0}}, 4'b0101);

    wait_idle();
    write_reg(REG_SLAVE, 64'b1010);
    cfg_we <= 1'b0;
    send_tick({-16'sd450, 16'sd300, 16'sd700, 16'sd1000}, {4{16'sd0}}, 4'b0000);
    send_tick({-16'sd450, 16'sd300, 16'sd700, 16'sd1000}, {4{16'sd10}}, 4'b1000);

    wait_idle();
    write_reg(REG_SLAVE, 64'b1111);
    cfg_we <= 1'b0;
    send_tick({16'sd1, 16'sd2, 16'sd3, 16'sd4}, {4{16'sd0}}, 4'b0000);

    wait_idle();
    write_reg(REG_SPARE, '1);
    cfg_we <= 1'b0;
    send_tick({16'sd1, 16'sd2, 16'sd3, 16'sd4}, {4{16'sd0}}, 4'b0000);

    wait_idle();
    write_reg(REG_SLAVE, 64'b0000);
    cfg_we <= 1'b0;
    send_tick({16'sd250, -16'sd250, 16'sd125, -16'sd125}, {4{16'sd0}}, 4'b0000);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      apply_random_setting();
      calm = ($urandom_range(0, 3) == 0);
      for (n = 0; n < TICKS_PER_PHASE; n++) begin
        send_random_tick();
      end
    end
    calm = 1'b0;

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("Sent %0d control ticks with %0d register writes over %0d random settings.",
             tick_count, write_count, RANDOM_PHASES);
    $display("Compared %0d sets of four drive values.", checked_count);
    if (pending_count != 0) begin
      $display("%0d ticks never returned drive values", pending_count);
    end
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/qipid_pkg.sv
hdl/qipid_if.sv
hdl/qipid_ram.sv
hdl/quad_incremental_pid_with_slaving.sv
hdl/qipid_checker.sv
test/qipid_checker.sv
test/tb_quad_incremental_pid_with_slaving.sv
